// File: rtl/lwsc_pkg.sv
// ----------------------------------------------------------------------------
// lwsc_pkg: shared types and constants of the sector cache tag engine
// Request and response payloads, command codes and the control word that the
// top level broadcasts to every cell of the recency chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lwsc_pkg;

  // Width of the slot field in a response.
  localparam int SLOT_OUT_W = 6;
  // Width of a sector number.
  localparam int SECTOR_W = 32;
  // Most write-back responses that one flush reports.
  localparam int MAX_RESULTS = 64;
  // Width of the flush response counter, holds 0..MAX_RESULTS.
  localparam int FLUSH_W = 7;

  // Request command codes.
  typedef enum logic [1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_PREFETCH = 2'd2,
    MODE_FLUSH    = 2'd3
  } lwsc_mode_e;

  // Request payload.
  typedef struct packed {
    logic [1:0]          mode;
    logic [SECTOR_W-1:0] sector;
  } lwsc_req_t;

  // Response payload.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  fill_needed;
    logic                  writeback_needed;
    logic [SECTOR_W-1:0]   writeback_sector;
    logic                  last;
  } lwsc_rsp_t;

  // Operation applied to the whole chain at once.
  typedef enum logic [1:0] {
    CELL_HOLD,        // keep contents
    CELL_MOVE,        // cells up to the chosen position take their left neighbor
    CELL_SHIFT_LEFT,  // every cell takes its right neighbor (flush walk)
    CELL_CLEAR        // every cell becomes empty
  } lwsc_cell_op_e;

  // Control word broadcast to all cells.
  typedef struct packed {
    lwsc_cell_op_e op;
    logic          cmp_en;
  } lwsc_ctl_t;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESOLVE,
    ST_UPDATE,
    ST_FLUSH
  } lwsc_state_e;

endpackage

`default_nettype wire

// File: rtl/lwsc_cell.sv
// ----------------------------------------------------------------------------
// lwsc_cell: one position of the recency chain
// Holds the slot number, sector tag and dirty mark of the entry at this
// recency position, compares its tag with an incoming sector, and takes the
// entry of its left or right neighbor when the chain moves.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsc_cell #(
  parameter int IDX = 0,
  parameter int SW  = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lwsc_pkg::lwsc_ctl_t           ctl,
  input  wire logic [lwsc_pkg::SECTOR_W-1:0] sector,
  input  wire logic [SW-1:0]                 pos,
  input  wire logic                          left_valid,
  input  wire logic [SW-1:0]                 left_slot,
  input  wire logic [lwsc_pkg::SECTOR_W-1:0] left_tag,
  input  wire logic                          left_dirty,
  input  wire logic                          right_valid,
  input  wire logic [SW-1:0]                 right_slot,
  input  wire logic [lwsc_pkg::SECTOR_W-1:0] right_tag,
  input  wire logic                          right_dirty,
  output logic                               valid,
  output logic [SW-1:0]                      slot,
  output logic [lwsc_pkg::SECTOR_W-1:0]      tag,
  output logic                               dirty,
  output logic                               match
);
  import lwsc_pkg::*;

  logic take_left;

  // This cell moves when the chosen position is at or beyond it.
  assign take_left = (int'(pos) >= IDX);

  // Occupancy bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_MOVE: begin
          if (take_left) valid <= left_valid;
        end
        CELL_SHIFT_LEFT: valid <= right_valid;
        CELL_CLEAR:      valid <= 1'b0;
        default:         valid <= valid;
      endcase
    end
  end

  // Entry contents; meaningful only while the cell is occupied.
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_MOVE: begin
        if (take_left) begin
          slot  <= left_slot;
          tag   <= left_tag;
          dirty <= left_dirty;
        end
      end
      CELL_SHIFT_LEFT: begin
        slot  <= right_slot;
        tag   <= right_tag;
        dirty <= right_dirty;
      end
      default: begin
        slot  <= slot;
        tag   <= tag;
        dirty <= dirty;
      end
    endcase
  end

  // Tag compare against the sector of an incoming request.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.cmp_en) begin
      match <= valid && (tag == sector);
    end
  end

endmodule

`default_nettype wire

// File: rtl/lwsc_lookup.sv
// ----------------------------------------------------------------------------
// lwsc_lookup: registered reduction of the chain's match flags
// Turns the single matching cell, if any, into its recency position, slot
// number and dirty mark. At most one cell matches, so the fields are ORed.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsc_lookup #(
  parameter int N  = 64,
  parameter int SW = 6
) (
  input  wire logic                   clk,
  input  wire logic [N-1:0]           match,
  input  wire logic [N-1:0][SW-1:0]   slot,
  input  wire logic [N-1:0]           dirty,
  output logic                        hit,
  output logic [SW-1:0]               hit_pos,
  output logic [SW-1:0]               hit_slot,
  output logic                        hit_dirty
);

  logic [SW-1:0] pos_c;
  logic [SW-1:0] slot_c;
  logic          dirty_c;

  // OR together the fields of the matching cell.
  always_comb begin
    pos_c   = '0;
    slot_c  = '0;
    dirty_c = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) begin
        pos_c   = pos_c | SW'(i);
        slot_c  = slot_c | slot[i];
        dirty_c = dirty_c | dirty[i];
      end
    end
  end

  // Lookup result register.
  always_ff @(posedge clk) begin
    hit       <= |match;
    hit_pos   <= pos_c;
    hit_slot  <= slot_c;
    hit_dirty <= dirty_c;
  end

endmodule

`default_nettype wire

// File: rtl/lru_writeback_sector_cache_top.sv
// Read, write and prefetch: a request is taken in the idle state, compared in
// the chain at that edge, resolved by the lookup register in the resolve state,
// and its response is registered in the update state once the response side is
// free; no new request is taken until then. Flush walks the recency chain one
// position per cycle, holding at a dirty entry while the response side stalls.
// Synchronous reset empties the chain and zeroes the counters.
// ----------------------------------------------------------------------------
// lru_writeback_sector_cache_top: tag and replacement engine of a fully
// associative write-back sector cache
// A chain of cells keeps the entries in recency order, most recent at cell 0.
// The sequencer resolves hits, fills and evictions, and walks the chain on a
// flush to report every dirty entry for write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_writeback_sector_cache_top #(
  parameter int CACHE_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire lwsc_pkg::lwsc_req_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output lwsc_pkg::lwsc_rsp_t      rsp
);
  import lwsc_pkg::*;

  localparam int N  = CACHE_ENTRIES;
  localparam int SW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);

  lwsc_state_e state, state_next;

  logic [1:0]          req_mode;
  logic [SECTOR_W-1:0] req_sector;
  logic [CW-1:0]       used_count, used_count_next;
  logic [CW-1:0]       dirty_count, dirty_count_next;
  logic [FLUSH_W-1:0]  flush_left, flush_left_next;

  logic      accept;
  logic      out_free;
  logic      emit;
  logic      is_write;
  logic      is_full;
  lwsc_rsp_t rsp_d;
  lwsc_ctl_t cell_ctl;
  logic [SW-1:0] upd_pos;
  logic [SW-1:0] new_slot;
  logic          new_dirty;

  // Chain links: index 0 is the entry fed into cell 0, index i+1 is the
  // output of cell i, and the last index is an empty entry.
  logic                c_valid [0:N+1];
  logic [SW-1:0]       c_slot  [0:N+1];
  logic [SECTOR_W-1:0] c_tag   [0:N+1];
  logic                c_dirty [0:N+1];

  logic [N-1:0]         match_vec;
  logic [N-1:0]         valid_vec;
  logic [N-1:0][SW-1:0] slot_vec;
  logic [N-1:0]         dirty_vec;

  logic          lk_hit;
  logic [SW-1:0] lk_pos;
  logic [SW-1:0] lk_slot;
  logic          lk_dirty;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign is_write = (req_mode == MODE_WRITE);
  assign is_full  = (int'(used_count) == N);

  // Chain ends.
  assign c_valid[0]   = 1'b1;
  assign c_slot[0]    = new_slot;
  assign c_tag[0]     = req_sector;
  assign c_dirty[0]   = new_dirty;
  assign c_valid[N+1] = 1'b0;
  assign c_slot[N+1]  = '0;
  assign c_tag[N+1]   = '0;
  assign c_dirty[N+1] = 1'b0;

  // Recency chain.
  for (genvar i = 0; i < N; i++) begin : g_cell
    lwsc_cell #(
      .IDX (i),
      .SW  (SW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .sector      (req.sector),
      .pos         (upd_pos),
      .left_valid  (c_valid[i]),
      .left_slot   (c_slot[i]),
      .left_tag    (c_tag[i]),
      .left_dirty  (c_dirty[i]),
      .right_valid (c_valid[i+2]),
      .right_slot  (c_slot[i+2]),
      .right_tag   (c_tag[i+2]),
      .right_dirty (c_dirty[i+2]),
      .valid       (c_valid[i+1]),
      .slot        (c_slot[i+1]),
      .tag         (c_tag[i+1]),
      .dirty       (c_dirty[i+1]),
      .match       (match_vec[i])
    );
    assign valid_vec[i] = c_valid[i+1];
    assign slot_vec[i]  = c_slot[i+1];
    assign dirty_vec[i] = c_dirty[i+1];
  end

  // Match reduction.
  lwsc_lookup #(
    .N  (N),
    .SW (SW)
  ) u_lookup (
    .clk       (clk),
    .match     (match_vec),
    .slot      (slot_vec),
    .dirty     (dirty_vec),
    .hit       (lk_hit),
    .hit_pos   (lk_pos),
    .hit_slot  (lk_slot),
    .hit_dirty (lk_dirty)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.mode == MODE_FLUSH) ? ST_FLUSH : ST_RESOLVE;
        end
      end
      ST_RESOLVE: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free && ((flush_left == '0) ||
            (c_valid[1] && c_dirty[1] && (flush_left == FLUSH_W'(1))))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Chain control, counters and response.
  always_comb begin
    cell_ctl         = '{op: CELL_HOLD, cmp_en: 1'b0};
    emit             = 1'b0;
    rsp_d            = '0;
    upd_pos          = '0;
    new_slot         = '0;
    new_dirty        = 1'b0;
    used_count_next  = used_count;
    dirty_count_next = dirty_count;
    flush_left_next  = flush_left;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_FLUSH) begin
            flush_left_next = (int'(dirty_count) > MAX_RESULTS) ?
                              FLUSH_W'(MAX_RESULTS) : FLUSH_W'(dirty_count);
          end else begin
            cell_ctl.cmp_en = 1'b1;
          end
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          emit       = 1'b1;
          rsp_d.last = 1'b1;
          if (lk_hit) begin
            // Hit: move to the front unless it is a prefetch.
            rsp_d.hit  = 1'b1;
            rsp_d.slot = SLOT_OUT_W'(lk_slot);
            if (req_mode != MODE_PREFETCH) begin
              cell_ctl.op      = CELL_MOVE;
              upd_pos          = lk_pos;
              new_slot         = lk_slot;
              new_dirty        = lk_dirty || is_write;
              dirty_count_next = dirty_count + CW'(is_write && !lk_dirty);
            end
          end else if (!is_full) begin
            // Miss with a free slot: take the next one in order.
            cell_ctl.op       = CELL_MOVE;
            upd_pos           = SW'(used_count);
            new_slot          = SW'(used_count);
            new_dirty         = is_write;
            used_count_next   = used_count + CW'(1);
            dirty_count_next  = dirty_count + CW'(is_write);
            rsp_d.slot        = SLOT_OUT_W'(SW'(used_count));
            rsp_d.fill_needed = 1'b1;
          end else begin
            // Miss in a full cache: evict the least recent entry.
            cell_ctl.op            = CELL_MOVE;
            upd_pos                = SW'(N - 1);
            new_slot               = c_slot[N];
            new_dirty              = is_write;
            dirty_count_next       = dirty_count + CW'(is_write) - CW'(c_dirty[N]);
            rsp_d.slot             = SLOT_OUT_W'(c_slot[N]);
            rsp_d.fill_needed      = 1'b1;
            rsp_d.writeback_needed = c_dirty[N];
            rsp_d.writeback_sector = c_dirty[N] ? c_tag[N] : '0;
          end
        end
      end
      ST_FLUSH: begin
        if (flush_left == '0) begin
          // Nothing dirty: one empty final response.
          if (out_free) begin
            emit             = 1'b1;
            rsp_d.last       = 1'b1;
            cell_ctl.op      = CELL_CLEAR;
            used_count_next  = '0;
            dirty_count_next = '0;
          end
        end else if (c_valid[1] && c_dirty[1]) begin
          // Dirty entry at the head of the chain: report it.
          if (out_free) begin
            emit                   = 1'b1;
            rsp_d.slot             = SLOT_OUT_W'(c_slot[1]);
            rsp_d.writeback_needed = 1'b1;
            rsp_d.writeback_sector = c_tag[1];
            rsp_d.last             = (flush_left == FLUSH_W'(1));
            flush_left_next        = flush_left - FLUSH_W'(1);
            if (flush_left == FLUSH_W'(1)) begin
              cell_ctl.op      = CELL_CLEAR;
              used_count_next  = '0;
              dirty_count_next = '0;
            end else begin
              cell_ctl.op = CELL_SHIFT_LEFT;
            end
          end
        end else begin
          // Clean entry: skip it.
          cell_ctl.op = CELL_SHIFT_LEFT;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      used_count  <= '0;
      dirty_count <= '0;
      flush_left  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      used_count  <= used_count_next;
      dirty_count <= dirty_count_next;
      flush_left  <= flush_left_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode   <= req.mode;
      req_sector <= req.sector;
    end
    if (emit) begin
      rsp <= rsp_d;
    end
  end

`ifndef SYNTH
  // A sector is cached in at most one entry.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESOLVE) |-> $onehot0(match_vec))
    else $error("more than one chain entry matched the request sector");

  // Dirty entries are a subset of the occupied ones.
  a_dirty_bound: assert property (@(posedge clk) disable iff (rst)
    (dirty_count <= used_count) && (int'(used_count) <= N))
    else $error("dirty or used count out of range");

  // Between requests the occupied cells match the used count.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid_vec) == int'(used_count)))
    else $error("chain occupancy differs from used count");

  // While dirty entries remain to be reported the chain head is occupied.
  a_flush_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && flush_left != '0) |-> c_valid[1])
    else $error("flush walked past the last occupied entry");
`endif

endmodule

`default_nettype wire

// File: tb/tb_lru_writeback_sector_cache_top.sv
// ----------------------------------------------------------------------------
// tb_lru_writeback_sector_cache_top: self-checking bench for the sector cache
// tag engine.
// A shadow copy of the tags, dirty marks and recency order predicts every
// response as each request is taken. Checked responses must match field by
// field and in order. The stimulus covers flushes on an empty and a clean
// cache, hits and misses of every request kind, a fill past capacity with
// dirty evictions, a flush of a fully dirty cache, and random mixed traffic.
// Sender bursts and gaps, receiver stall patterns, one long receiver hold-off
// and several full drains exercise the handshakes.
// ----------------------------------------------------------------------------

module tb_lru_writeback_sector_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lwsc_pkg::*;

  localparam int SLOTS = 64;
  localparam int POOL_SIZE = 80;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AFTER_REQS = 100;

  // A request waiting to be offered, and whether the sender first waits
  // until every outstanding response has come back.
  typedef struct packed {
    logic      drain_first;
    lwsc_req_t rq;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  lwsc_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  lwsc_rsp_t rsp;

  // Shadow of the cache: tags, dirty marks, slots most recent first.
  logic [SECTOR_W-1:0]   shadow_tag [SLOTS];
  logic                  shadow_dirty [SLOTS];
  logic [SLOT_OUT_W-1:0] shadow_lru [SLOTS];
  int                    shadow_used = 0;

  queued_req_t req_backlog [$];
  lwsc_rsp_t   rsp_due_q [$];
  lwsc_rsp_t   due_rsp;

  int errors = 0;
  int reqs_taken = 0;
  int rsps_seen = 0;
  int hit_cnt = 0;
  int fill_cnt = 0;
  int wb_cnt = 0;
  int flush_cnt = 0;
  int burst_left = 4;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_style = 0;
  int style_left = 0;
  int idle_cycles = 0;

  lru_writeback_sector_cache_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Move the slot at recency position pos to the most recent place.
  task automatic promote(input int pos);
    logic [SLOT_OUT_W-1:0] s;
    s = shadow_lru[pos];
    for (int i = pos; i > 0; i--) shadow_lru[i] = shadow_lru[i-1];
    shadow_lru[0] = s;
  endtask

  // Update the shadow cache for one request and queue the responses it owes.
  task automatic predict_access(input lwsc_req_t r);
    lwsc_rsp_t             res;
    logic [SLOT_OUT_W-1:0] s;
    int                    pos;
    int                    n_dirty;
    int                    n_sent;
    bit                    found;
    res = '0;
    if (r.mode == MODE_FLUSH) begin
      n_dirty = 0;
      n_sent = 0;
      for (int i = 0; i < shadow_used; i++) begin
        if (shadow_dirty[shadow_lru[i]]) n_dirty++;
      end
      // One write-back per dirty entry, most recent first.
      for (int i = 0; i < shadow_used; i++) begin
        s = shadow_lru[i];
        if (shadow_dirty[s]) begin
          n_sent++;
          res = '0;
          res.slot = s;
          res.writeback_needed = 1'b1;
          res.writeback_sector = shadow_tag[s];
          res.last = (n_sent == n_dirty);
          rsp_due_q.push_back(res);
        end
      end
      for (int i = 0; i < SLOTS; i++) shadow_dirty[i] = 1'b0;
      shadow_used = 0;
      // A clean cache still answers with one empty response.
      if (n_dirty == 0) begin
        res = '0;
        res.last = 1'b1;
        rsp_due_q.push_back(res);
      end
    end else begin
      found = 1'b0;
      pos = 0;
      while (!found && pos < shadow_used) begin
        if (shadow_tag[shadow_lru[pos]] == r.sector) found = 1'b1;
        else pos++;
      end
      res.last = 1'b1;
      if (found) begin
        // Prefetch hits leave the recency order alone.
        s = shadow_lru[pos];
        if (r.mode != MODE_PREFETCH) promote(pos);
        if (r.mode == MODE_WRITE) shadow_dirty[s] = 1'b1;
        res.hit = 1'b1;
        res.slot = s;
      end else begin
        if (shadow_used < SLOTS) begin
          s = SLOT_OUT_W'(shadow_used);
          shadow_lru[shadow_used] = s;
          promote(shadow_used);
          shadow_used++;
        end else begin
          // Full: evict the least recent slot, writing it back if dirty.
          s = shadow_lru[SLOTS-1];
          promote(SLOTS - 1);
          res.writeback_needed = shadow_dirty[s];
          if (shadow_dirty[s]) res.writeback_sector = shadow_tag[s];
        end
        shadow_tag[s] = r.sector;
        shadow_dirty[s] = (r.mode == MODE_WRITE);
        res.slot = s;
        res.fill_needed = 1'b1;
      end
      rsp_due_q.push_back(res);
    end
  endtask

  task automatic add_req(input lwsc_mode_e m, input logic [SECTOR_W-1:0] sec,
                         input logic drain);
    queued_req_t q;
    q.drain_first = drain;
    q.rq.mode = m;
    q.rq.sector = sec;
    req_backlog.push_back(q);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Sender: offers queued requests in bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_access(req);
        reqs_taken++;
        if (req.mode == MODE_FLUSH) flush_cnt++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() != 0 &&
                     !(req_backlog[0].drain_first && rsp_due_q.size() != 0)) begin
          req <= req_backlog[0].rq;
          req_valid <= 1'b1;
          void'(req_backlog.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks responses and stalls on its own pattern.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsps_seen++;
        if (rsp_due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
        end else begin
          due_rsp = rsp_due_q.pop_front();
          check_field("hit", 32'(due_rsp.hit), 32'(rsp.hit));
          check_field("slot", 32'(due_rsp.slot), 32'(rsp.slot));
          check_field("fill_needed", 32'(due_rsp.fill_needed),
                      32'(rsp.fill_needed));
          check_field("writeback_needed", 32'(due_rsp.writeback_needed),
                      32'(rsp.writeback_needed));
          check_field("writeback_sector", due_rsp.writeback_sector,
                      rsp.writeback_sector);
          check_field("last", 32'(due_rsp.last), 32'(rsp.last));
          if (due_rsp.hit) hit_cnt++;
          if (due_rsp.fill_needed) fill_cnt++;
          if (due_rsp.writeback_needed) wb_cnt++;
        end
      end
      // One long hold-off once traffic is well under way.
      if (!hold_done && reqs_taken >= HOLD_AFTER_REQS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left = $urandom_range(16, 64);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (stall_style)
          0: begin
            rsp_stall <= 1'b0;
          end
          1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            rsp_stall <= ($urandom_range(0, 1) == 1);
          end
        endcase
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [SECTOR_W-1:0] pool [POOL_SIZE];
    logic [SECTOR_W-1:0] base;
    logic [SECTOR_W-1:0] sec;
    lwsc_mode_e          m;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_dirty[i] = 1'b0;
      shadow_tag[i] = '0;
      shadow_lru[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
    base = $urandom;

    // Directed: empty flush, hits and misses of each kind, extreme sectors,
    // a flush with dirty entries, then a clean flush.
    add_req(MODE_FLUSH, 32'h0000_0000, 1'b0);
    add_req(MODE_READ, 32'h0000_0000, 1'b0);
    add_req(MODE_WRITE, 32'hFFFF_FFFF, 1'b0);
    add_req(MODE_READ, 32'h0000_0000, 1'b0);
    add_req(MODE_PREFETCH, 32'hFFFF_FFFF, 1'b0);
    add_req(MODE_PREFETCH, 32'h1234_5678, 1'b0);
    add_req(MODE_WRITE, 32'h0000_0000, 1'b0);
    add_req(MODE_WRITE, 32'h1234_5678, 1'b0);
    add_req(MODE_READ, 32'hFFFF_FFFF, 1'b0);
    add_req(MODE_FLUSH, 32'hDEAD_BEEF, 1'b0);
    add_req(MODE_FLUSH, 32'h0000_0000, 1'b0);
    add_req(MODE_READ, 32'hA5A5_A5A5, 1'b0);
    add_req(MODE_PREFETCH, 32'h5A5A_5A5A, 1'b0);
    add_req(MODE_WRITE, 32'h8000_0000, 1'b0);
    add_req(MODE_FLUSH, 32'hFFFF_FFFF, 1'b0);

    // Overfill with writes so dirty slots get evicted, then flush a cache
    // where every entry is dirty.
    for (int i = 0; i < SLOTS + 8; i++) add_req(MODE_WRITE, base + i, i == 0);
    add_req(MODE_FLUSH, $urandom, 1'b0);

    // Mixed traffic over a pool larger than the cache: hits, evictions.
    for (int i = 0; i < 90; i++) begin
      m = lwsc_mode_e'($urandom_range(0, 2));
      sec = ($urandom_range(0, 6) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
      add_req(m, sec, i == 0);
    end

    // Mixed traffic with occasional flushes over a smaller working set.
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 11) == 0) m = MODE_FLUSH;
      else m = lwsc_mode_e'($urandom_range(0, 2));
      sec = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 39)];
      add_req(m, sec, i == 0);
    end
    add_req(MODE_FLUSH, $urandom, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || req_valid || rsp_due_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests including %0d flushes; %0d responses checked.",
             reqs_taken, flush_cnt, rsps_seen);
    $display("Responses held %0d hits, %0d fills and %0d write-backs.",
             hit_cnt, fill_cnt, wb_cnt);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: lru_writeback_sector_cache_top.f
rtl/lwsc_pkg.sv
rtl/lwsc_cell.sv
rtl/lwsc_lookup.sv
rtl/lru_writeback_sector_cache_top.sv
tb/tb_lru_writeback_sector_cache_top.sv
